FILE: sv/ccs_pkg.sv
// Shared types, constants and helper functions of the calendar clock event scheduler.
package ccs_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CfgTelemetrySecond = 2'd0;
    localparam logic [1:0] CfgAsyncLead       = 2'd1;
    localparam logic [1:0] CfgBeaconEnable    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [5:0] TelemetrySecondReset = 6'd30;
    localparam logic [5:0] AsyncLeadReset       = 6'd5;
    localparam logic       BeaconEnableReset    = 1'b1;

    // Bit positions inside the event flag word.
    localparam int FlagCollect  = 0;
    localparam int FlagAsync    = 1;
    localparam int FlagTelem    = 2;
    localparam int FlagPip      = 3;
    localparam int FlagBeacon   = 4;
    localparam int FlagGeofence = 5;
    localparam int FlagKick     = 6;
    localparam int FlagBacklog  = 7;
    localparam int FlagGpsReq   = 8;
    localparam int FlagCount    = 9;

    // Calendar limits.
    localparam logic [6:0] SecondsPerMinute = 7'd60;
    localparam logic [6:0] MinutesPerHour   = 7'd60;
    localparam logic [5:0] HoursPerDay      = 6'd24;
    localparam logic [4:0] MonthsPerYear    = 5'd12;

    // Divisibility by 25 of a 16-bit value: multiply by the inverse of 25
    // modulo 2^16, the value divides exactly when the product stays small.
    localparam logic [15:0] Inv25Mod16 = 16'd23593;
    localparam logic [15:0] Div25Limit = 16'd2621;

    // Stream payload widths.
    localparam int InDataWidth  = 48;
    localparam int OutDataWidth = 88;

    // Time of day and date as held by the clock.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } time_t;

    // Configuration seen by the scheduler.
    typedef struct packed {
        logic [5:0] telemetry_second;
        logic [5:0] async_second;
        logic       beacon_enable;
    } cfg_t;

    // Gregorian leap-year test on a 16-bit year.
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * 32'(Inv25Mod16);
        div25 = (prod[15:0] <= Div25Limit);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // Days in a month; any month code outside February and the short
    // months counts as 31 days.
    function automatic logic [5:0] month_length(input logic [3:0] mon,
                                                input logic [15:0] y);
        logic [5:0] len;
        case (mon)
            4'd2:                      len = is_leap(y) ? 6'd29 : 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 6'd30;
            default:                   len = 6'd31;
        endcase
        return len;
    endfunction

    // True when a 6-bit minute is a multiple of five.
    function automatic logic is_mult5(input logic [5:0] m);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 12; k++) begin
            hit = hit | (m == 6'(5 * k));
        end
        return hit;
    endfunction

endpackage

FILE: sv/ccs_cfg_regs.sv
// Configuration registers and the derived async collection second.
module ccs_cfg_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [5:0]      cfg_wdata,
    output ccs_pkg::cfg_t   cfg
);
    import ccs_pkg::*;

    logic [5:0] telem_sec_reg;
    logic [5:0] lead_reg;
    logic       beacon_en_reg;
    logic [7:0] async_raw;

    // Register writes; an index with no register is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            telem_sec_reg <= TelemetrySecondReset;
            lead_reg      <= AsyncLeadReset;
            beacon_en_reg <= BeaconEnableReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgTelemetrySecond: telem_sec_reg <= cfg_wdata;
                CfgAsyncLead:       lead_reg      <= cfg_wdata;
                CfgBeaconEnable:    beacon_en_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Async second is (telemetry second + 120 - lead) modulo 60; the raw
    // value lies between 57 and 183, so at most three subtractions of 60.
    assign async_raw = 8'(telem_sec_reg) + 8'd120 - 8'(lead_reg);

    always_comb begin
        cfg.telemetry_second = telem_sec_reg;
        cfg.beacon_enable    = beacon_en_reg;
        if (async_raw >= 8'd180) begin
            cfg.async_second = 6'(async_raw - 8'd180);
        end else if (async_raw >= 8'd120) begin
            cfg.async_second = 6'(async_raw - 8'd120);
        end else if (async_raw >= 8'd60) begin
            cfg.async_second = 6'(async_raw - 8'd60);
        end else begin
            cfg.async_second = 6'(async_raw);
        end
    end

endmodule

FILE: sv/ccs_calendar.sv
// Held time, epoch counter and UTC flag, with the one-second carry chain.
module ccs_calendar (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             load,
    input  ccs_pkg::time_t   set_time,
    input  logic             set_utc_valid,
    output ccs_pkg::time_t   time_next,
    output logic [31:0]      epoch_next,
    output logic             utc_valid_next
);
    import ccs_pkg::*;

    time_t       time_reg;
    logic [31:0] epoch_reg;
    logic        utc_valid_reg;

    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  mon_inc;
    logic [5:0]  mon_len;

    assign sec_inc  = 7'(time_reg.second) + 7'd1;
    assign min_inc  = 7'(time_reg.minute) + 7'd1;
    assign hour_inc = 6'(time_reg.hour) + 6'd1;
    assign day_inc  = 6'(time_reg.day) + 6'd1;
    assign mon_inc  = 5'(time_reg.month) + 5'd1;
    assign mon_len  = month_length(time_reg.month, time_reg.year);

    // Next time: a load copies the fields, a tick carries up the chain.
    always_comb begin
        time_next      = time_reg;
        epoch_next     = epoch_reg;
        utc_valid_next = utc_valid_reg;
        if (load) begin
            time_next      = set_time;
            utc_valid_next = set_utc_valid;
        end else begin
            epoch_next = epoch_reg + 32'd1;
            if (sec_inc < SecondsPerMinute) begin
                time_next.second = sec_inc[5:0];
            end else begin
                time_next.second = 6'd0;
                if (min_inc < MinutesPerHour) begin
                    time_next.minute = min_inc[5:0];
                end else begin
                    time_next.minute = 6'd0;
                    if (hour_inc < HoursPerDay) begin
                        time_next.hour = hour_inc[4:0];
                    end else begin
                        time_next.hour = 5'd0;
                        if (day_inc <= mon_len) begin
                            time_next.day = day_inc[4:0];
                        end else begin
                            time_next.day = 5'd1;
                            if (mon_inc <= MonthsPerYear) begin
                                time_next.month = mon_inc[3:0];
                            end else begin
                                time_next.month = 4'd1;
                                time_next.year  = time_reg.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // State update once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            epoch_reg     <= '0;
            utc_valid_reg <= 1'b0;
        end else if (step) begin
            time_reg      <= time_next;
            epoch_reg     <= epoch_next;
            utc_valid_reg <= utc_valid_next;
        end
    end

endmodule

FILE: sv/ccs_sched.sv
// Schedule strobe decoder and the telemetry wake-up flag.
module ccs_sched (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                load,
    input  ccs_pkg::time_t      time_now,
    input  logic                utc_valid,
    input  ccs_pkg::cfg_t       cfg,
    input  logic                gps_locked,
    input  logic                tx_allowed,
    output logic [8:0]          flags
);
    import ccs_pkg::*;

    logic woken_reg;
    logic at_telem;
    logic sec_zero;
    logic top_of_hour;

    assign at_telem    = (time_now.second == cfg.telemetry_second);
    assign sec_zero    = (time_now.second == 6'd0);
    assign top_of_hour = sec_zero && (time_now.minute == 6'd0);

    // Strobes from the new time; a load raises none, and the telemetry
    // group stays quiet on the first tick after reset.
    always_comb begin
        flags = '0;
        if (!load) begin
            flags[FlagCollect] = at_telem;
            flags[FlagAsync]   = !at_telem && (time_now.second == cfg.async_second);
            if (woken_reg) begin
                flags[FlagTelem]    = tx_allowed && at_telem;
                flags[FlagPip]      = tx_allowed && !at_telem;
                flags[FlagBeacon]   = cfg.beacon_enable && !time_now.minute[0] && at_telem;
                flags[FlagGeofence] = is_mult5(time_now.minute) && sec_zero && gps_locked;
            end
            flags[FlagKick]    = top_of_hour;
            flags[FlagBacklog] = top_of_hour && gps_locked;
            flags[FlagGpsReq]  = (top_of_hour && (time_now.hour == 5'd0))
                                 || (sec_zero && !utc_valid);
        end
    end

    // The first processed tick wakes telemetry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            woken_reg <= 1'b0;
        end else if (step && !load) begin
            woken_reg <= 1'b1;
        end
    end

endmodule

FILE: sv/calendar_clock_event_scheduler_core.sv
// Top level of the calendar clock event scheduler.
//
// Input items arrive on the s_ stream: s_tuser is the kind (0 one-second
// tick, 1 load of a GPS time) and s_tdata carries the time to load and the
// GPS lock and transmit-allowed flags. Each input item produces exactly one
// result item on the m_ stream with the time now held, the epoch count, the
// UTC flag and the schedule strobes (all zero for a load).
// Configuration registers (telemetry second, async lead, beacon enable) are
// written through cfg_wr_en, cfg_index and cfg_wdata while no item is in
// flight; indexes with no register are ignored.
// An accepted item waits in the input register while the calendar carry
// chain and strobe decoder work on it; when the output register is free,
// its result enters the output register and m_tvalid rises. One item per
// cycle is sustained while the receiver is ready.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more item; s_tready falls only when
// both are full. A synchronous low aresetn clears the time, epoch count,
// UTC flag and wake-up flag to zero, empties both registers and restores
// the configuration defaults (30, 5, enabled).
module calendar_clock_event_scheduler_core (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: set_year[16], set_month[4], set_day[5], set_hour[5],
    // set_minute[6], set_second[6], set_utc_valid, gps_locked, tx_allowed, pad[3]
    input  logic [47:0]  s_tdata,
    // tuser: kind
    input  logic         s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: year_now[16], month_now[4], day_now[5], hour_now[5],
    // minute_now[6], second_now[6], epoch_count[32], utc_valid_now,
    // event_flags[9], pad[4]
    output logic [87:0]  m_tdata,
    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_wdata
);
    import ccs_pkg::*;

    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [InDataWidth-1:0]   in_data_reg;
    logic                     in_kind_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [OutDataWidth-1:0]  m_data_reg;
    logic [OutDataWidth-1:0]  m_data_next;

    logic        out_free;
    logic        step;
    logic        s_accept;
    cfg_t        cfg;
    time_t       set_time;
    time_t       time_next;
    logic [31:0] epoch_next;
    logic        utc_valid_next;
    logic [8:0]  flags;

    // Handshake: the work stage moves when the output register is free.
    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // Unpack the held input item.
    assign set_time.year   = in_data_reg[15:0];
    assign set_time.month  = in_data_reg[19:16];
    assign set_time.day    = in_data_reg[24:20];
    assign set_time.hour   = in_data_reg[29:25];
    assign set_time.minute = in_data_reg[35:30];
    assign set_time.second = in_data_reg[41:36];

    ccs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccs_calendar u_calendar (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .load           (in_kind_reg),
        .set_time       (set_time),
        .set_utc_valid  (in_data_reg[42]),
        .time_next      (time_next),
        .epoch_next     (epoch_next),
        .utc_valid_next (utc_valid_next)
    );

    ccs_sched u_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .load       (in_kind_reg),
        .time_now   (time_next),
        .utc_valid  (utc_valid_next),
        .cfg        (cfg),
        .gps_locked (in_data_reg[43]),
        .tx_allowed (in_data_reg[44]),
        .flags      (flags)
    );

    // Pack the result item.
    assign m_data_next = {4'd0, flags, utc_valid_next, epoch_next,
                          time_next.second, time_next.minute, time_next.hour,
                          time_next.day, time_next.month, time_next.year};

    // Valid flags of the input and output registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
        if (step) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: tb/tb_top.sv
// Testbench for the calendar clock event scheduler: directed and random items against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import ccs_pkg::*;

    // Item kinds carried on s_tuser.
    localparam logic KindTick = 1'b0;
    localparam logic KindLoad = 1'b1;

    // Register index with no register behind it.
    localparam logic [1:0] CfgUnmapped = 2'd3;

    // Receiver stall patterns.
    typedef enum int unsigned {RxSteady, RxCoin, RxPeriodic, RxSparse} rx_mode_e;

    // One input item: the time to load, its UTC flag and the two status flags.
    typedef struct {
        time_t stamp;
        logic  utc;
        logic  locked;
        logic  txok;
    } request_t;

    // One result item as the clock reports it.
    typedef struct {
        time_t       now;
        logic [31:0] epoch;
        logic        utc;
        logic [8:0]  flags;
    } reading_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [87:0]  m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [5:0]   cfg_wdata = '0;

    // Predicted clock state and configuration.
    time_t       held;
    logic [31:0] tick_count;
    logic        held_utc;
    logic        telemetry_awake;
    logic [5:0]  cfg_telemetry_sec;
    logic [5:0]  cfg_async_lead;
    logic        cfg_beacon_on;

    reading_t    pending_readings[$];
    int unsigned mismatch_count = 0;
    int unsigned readings_seen  = 0;
    int          burst_left     = 0;
    int unsigned ready_cycle    = 0;
    rx_mode_e    ready_mode     = RxSteady;

    calendar_clock_event_scheduler_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Days in a month, Gregorian; month codes outside the calendar count 31.
    function automatic int unsigned month_day_count(input logic [3:0] mon,
                                                    input logic [15:0] yr);
        logic leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mon)
            4'd2:                    return leap ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    // One second forward, carrying up through the year.
    function automatic void advance_calendar();
        int unsigned nxt;
        tick_count = tick_count + 32'd1;
        nxt = held.second + 1;
        if (nxt < SecondsPerMinute) begin
            held.second = 6'(nxt);
            return;
        end
        held.second = '0;
        nxt = held.minute + 1;
        if (nxt < MinutesPerHour) begin
            held.minute = 6'(nxt);
            return;
        end
        held.minute = '0;
        nxt = held.hour + 1;
        if (nxt < HoursPerDay) begin
            held.hour = 5'(nxt);
            return;
        end
        held.hour = '0;
        nxt = held.day + 1;
        if (nxt <= month_day_count(held.month, held.year)) begin
            held.day = 5'(nxt);
            return;
        end
        held.day = 5'd1;
        nxt = held.month + 1;
        if (nxt <= MonthsPerYear) begin
            held.month = 4'(nxt);
            return;
        end
        held.month = 4'd1;
        held.year  = held.year + 16'd1;
    endfunction

    // Schedule strobes decoded from the time just reached.
    function automatic logic [8:0] decode_strobes(input logic locked, input logic txok);
        logic [8:0]  f;
        int unsigned async_at;
        logic        at_telem;
        logic        top_of_minute;
        f = '0;
        async_at = (int'(cfg_telemetry_sec) + 120 - int'(cfg_async_lead)) % 60;
        at_telem = (held.second == cfg_telemetry_sec);
        top_of_minute = (held.second == 6'd0);
        if (at_telem) begin
            f[FlagCollect] = 1'b1;
        end else if (held.second == async_at) begin
            f[FlagAsync] = 1'b1;
        end
        // Telemetry, pip, beacon and geofence stay quiet on the first tick.
        if (telemetry_awake) begin
            if (txok) begin
                f[at_telem ? FlagTelem : FlagPip] = 1'b1;
            end
            if (cfg_beacon_on && !held.minute[0] && at_telem) begin
                f[FlagBeacon] = 1'b1;
            end
            if (held.minute % 5 == 0 && top_of_minute && locked) begin
                f[FlagGeofence] = 1'b1;
            end
        end else begin
            telemetry_awake = 1'b1;
        end
        if (held.minute == 6'd0 && top_of_minute) begin
            f[FlagKick]    = 1'b1;
            f[FlagBacklog] = locked;
        end
        if ((held.hour == 5'd0 && held.minute == 6'd0 && top_of_minute) ||
            (top_of_minute && !held_utc)) begin
            f[FlagGpsReq] = 1'b1;
        end
        return f;
    endfunction

    // Expected result of one accepted item; updates the predicted state.
    function automatic reading_t predict_reading(input logic kind, input request_t req);
        reading_t r;
        r.flags = '0;
        if (kind == KindLoad) begin
            held     = req.stamp;
            held_utc = req.utc;
        end else begin
            advance_calendar();
            r.flags = decode_strobes(req.locked, req.txok);
        end
        r.now   = held;
        r.epoch = tick_count;
        r.utc   = held_utc;
        return r;
    endfunction

    function automatic logic [47:0] pack_request(input request_t req);
        return {3'b000, req.txok, req.locked, req.utc, req.stamp.second, req.stamp.minute,
                req.stamp.hour, req.stamp.day, req.stamp.month, req.stamp.year};
    endfunction

    function automatic reading_t unpack_reading(input logic [87:0] d);
        reading_t r;
        r.now.year   = d[15:0];
        r.now.month  = d[19:16];
        r.now.day    = d[24:20];
        r.now.hour   = d[29:25];
        r.now.minute = d[35:30];
        r.now.second = d[41:36];
        r.epoch      = d[73:42];
        r.utc        = d[74];
        r.flags      = d[83:75];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string label, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                    readings_seen, label, got, want));
        end
    endtask

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_reading(m_tdata);
            if (pending_readings.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                        readings_seen));
            end else begin
                want = pending_readings.pop_front();
                compare_field("year",   got.now.year,   want.now.year);
                compare_field("month",  got.now.month,  want.now.month);
                compare_field("day",    got.now.day,    want.now.day);
                compare_field("hour",   got.now.hour,   want.now.hour);
                compare_field("minute", got.now.minute, want.now.minute);
                compare_field("second", got.now.second, want.now.second);
                compare_field("epoch",  got.epoch,      want.epoch);
                compare_field("utc",    got.utc,        want.utc);
                compare_field("flags",  got.flags,      want.flags);
            end
            readings_seen++;
        end
    end

    // Receiver backpressure: a randomly redrawn stall pattern drives m_tready.
    always @(posedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 48 == 0) begin
            ready_mode = rx_mode_e'($urandom_range(0, 3));
        end
        case (ready_mode)
            RxSteady:   m_tready <= 1'b1;
            RxCoin:     m_tready <= 1'($urandom_range(0, 1));
            RxPeriodic: m_tready <= (ready_cycle % 5 != 0);
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Sends one item in bursts with random gaps and records its prediction.
    task automatic offer_item(input logic kind, input request_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pack_request(req);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readings.push_back(predict_reading(kind, req));
    endtask

    // A tick; the unused time fields carry random content.
    task automatic tick(input logic locked, input logic txok);
        request_t    req;
        logic [63:0] noise;
        noise      = {$urandom, $urandom};
        req.stamp  = noise[41:0];
        req.utc    = noise[42];
        req.locked = locked;
        req.txok   = txok;
        offer_item(KindTick, req);
    endtask

    task automatic load_time(input logic [15:0] yr, input logic [3:0] mon,
                             input logic [4:0] dy, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [5:0] sc, input logic utc);
        request_t req;
        req.stamp  = '{year: yr, month: mon, day: dy, hour: hr, minute: mn, second: sc};
        req.utc    = utc;
        req.locked = 1'($urandom_range(0, 1));
        req.txok   = 1'($urandom_range(0, 1));
        offer_item(KindLoad, req);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CfgTelemetrySecond: cfg_telemetry_sec = val;
            CfgAsyncLead:       cfg_async_lead    = val;
            CfgBeaconEnable:    cfg_beacon_on     = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [5:0] tsec, input logic [5:0] lead,
                                  input logic beacon);
        wait_until_drained();
        write_register(CfgTelemetrySecond, tsec);
        write_register(CfgAsyncLead, lead);
        write_register(CfgBeaconEnable, {5'($urandom_range(0, 31)), beacon});
    endtask

    // Random load biased toward rollovers, leap days and out-of-range fields.
    function automatic request_t random_load_request();
        request_t    req;
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0, 1:    req.stamp.year = 16'($urandom);
            2:       req.stamp.year = 16'd2000;
            3:       req.stamp.year = 16'd1900;
            4:       req.stamp.year = 16'd2100;
            5:       req.stamp.year = 16'hFFFF;
            default: req.stamp.year = 16'($urandom_range(1980, 2104));
        endcase
        pick = $urandom_range(0, 7);
        case (pick)
            0:       req.stamp.month = 4'($urandom);
            1:       req.stamp.month = 4'd2;
            2:       req.stamp.month = 4'd12;
            default: req.stamp.month = 4'($urandom_range(1, 12));
        endcase
        len  = month_day_count(req.stamp.month, req.stamp.year);
        pick = $urandom_range(0, 5);
        case (pick)
            0:       req.stamp.day = 5'($urandom);
            1, 2:    req.stamp.day = 5'(len);
            3:       req.stamp.day = 5'(len - 1);
            default: req.stamp.day = 5'($urandom_range(1, 28));
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
            0:       req.stamp.hour = 5'($urandom);
            1, 2:    req.stamp.hour = 5'd23;
            default: req.stamp.hour = 5'($urandom_range(0, 23));
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
            0:       req.stamp.minute = 6'($urandom);
            1, 2:    req.stamp.minute = 6'd59;
            3:       req.stamp.minute = 6'(5 * $urandom_range(0, 11) + 4);
            default: req.stamp.minute = 6'($urandom_range(0, 59));
        endcase
        pick = $urandom_range(0, 7);
        case (pick)
            0:       req.stamp.second = 6'($urandom);
            1, 2, 3: req.stamp.second = 6'($urandom_range(50, 59));
            4:       req.stamp.second = cfg_telemetry_sec - 6'($urandom_range(0, 7));
            default: req.stamp.second = 6'($urandom_range(0, 59));
        endcase
        req.utc    = 1'($urandom_range(0, 1));
        req.locked = 1'($urandom_range(0, 1));
        req.txok   = 1'($urandom_range(0, 1));
        return req;
    endfunction

    // Ticks straight out of reset: zero time and the telemetry wake-up.
    task automatic test_wakeup();
        repeat (3) tick(1'b1, 1'b1);
    endtask

    // Year wrap, leap and non-leap Februaries and a 30-day month end.
    task automatic test_calendar_rollover();
        load_time(16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1);
        tick(1'b0, 1'b1);
        load_time(16'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b1);
        tick(1'b1, 1'b0);
        load_time(16'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 1'b1);
        tick(1'b0, 1'b0);
        load_time(16'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b1);
        tick(1'b1, 1'b1);
        load_time(16'd2024, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59, 1'b0);
        tick(1'b1, 1'b1);
    endtask

    // All-ones fields wrap on the next tick; month zero counts 31 days.
    task automatic test_out_of_range_time();
        load_time(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 1'b1);
        tick(1'b1, 1'b1);
        load_time(16'd0, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0);
        tick(1'b0, 1'b1);
    endtask

    // Hourly kick, collect with telemetry and beacon, async, GPS request.
    task automatic test_schedule_strobes();
        load_time(16'd2024, 4'd6, 5'd15, 5'd12, 6'd59, 6'd59, 1'b1);
        tick(1'b1, 1'b1);
        load_time(16'd2024, 4'd6, 5'd15, 5'd8, 6'd10, 6'd29, 1'b0);
        tick(1'b0, 1'b1);
        load_time(16'd2024, 4'd6, 5'd15, 5'd8, 6'd11, 6'd24, 1'b1);
        tick(1'b1, 1'b0);
        load_time(16'd2024, 4'd6, 5'd15, 5'd8, 6'd11, 6'd59, 1'b0);
        tick(1'b1, 1'b1);
    endtask

    // Loads followed by tick runs, with some bare runs and back-to-back loads.
    task automatic run_schedule_phase(input int item_goal);
        int sent;
        int shape;
        int run_len;
        sent = 0;
        while (sent < item_goal) begin
            shape = $urandom_range(0, 19);
            if (shape == 0) begin
                offer_item(KindLoad, random_load_request());
                sent++;
            end
            if (shape >= 3 || shape == 0) begin
                offer_item(KindLoad, random_load_request());
                sent++;
            end
            shape = $urandom_range(0, 9);
            run_len = (shape < 6) ? $urandom_range(1, 12) :
                      (shape < 9) ? $urandom_range(13, 40) : $urandom_range(60, 75);
            repeat (run_len) begin
                tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Random traffic under several settings, extremes first.
    task automatic test_random_schedule();
        logic [5:0] tsec;
        logic [5:0] lead;
        logic       beacon;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: begin tsec = TelemetrySecondReset; lead = AsyncLeadReset; beacon = 1'b1; end
                1: begin tsec = 6'd0;  lead = 6'd0;  beacon = 1'b1; end
                2: begin tsec = 6'd59; lead = 6'd59; beacon = 1'b0; end
                3: begin tsec = 6'd63; lead = 6'd63; beacon = 1'b1; end
                4: begin tsec = 6'd0;  lead = 6'd63; beacon = 1'b1; end
                5: begin tsec = 6'd59; lead = 6'd0;  beacon = 1'b0; end
                default: begin
                    tsec   = 6'($urandom_range(0, 63));
                    lead   = 6'($urandom_range(0, 63));
                    beacon = 1'($urandom_range(0, 1));
                end
            endcase
            if (phase != 0) begin
                apply_settings(tsec, lead, beacon);
            end
            // The unmapped index must leave every register alone.
            if (phase == 6) begin
                write_register(CfgUnmapped, 6'($urandom));
            end
            run_schedule_phase(42);
        end
    endtask

    // Reset, the tests in turn, then the verdict.
    initial begin
        int unsigned drain_cycles;
        cfg_telemetry_sec = TelemetrySecondReset;
        cfg_async_lead    = AsyncLeadReset;
        cfg_beacon_on     = BeaconEnableReset;
        held              = '0;
        tick_count        = '0;
        held_utc          = 1'b0;
        telemetry_awake   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_wakeup();
        test_calendar_rollover();
        test_out_of_range_time();
        test_schedule_strobes();
        test_random_schedule();

        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_readings.size() != 0 && drain_cycles < 5000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (pending_readings.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_readings.size()));
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/ccs_pkg.sv
sv/ccs_cfg_regs.sv
sv/ccs_calendar.sv
sv/ccs_sched.sv
sv/calendar_clock_event_scheduler_core.sv
tb/tb_top.sv
